// ===== hw/rtl/bdlp_pkg.sv =====
// Shared types, widths and register codes for the button debouncer with long-press detection.
`default_nettype none

package bdlp_pkg;

  localparam int COUNT_WIDTH = 8;
  localparam int TIME_WIDTH  = 32;

  localparam int NOW_W   = 32;
  localparam int THR_W   = 8;
  localparam int LPMS_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  // Wide enough to compare the 8-bit counter against the 8-bit threshold.
  localparam int CMP_W   = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS     = 2'd2;

  localparam logic             FILTER_MODE_RST       = 1'b1;
  localparam logic [THR_W-1:0] CONFIRM_THRESHOLD_RST = 8'd15;
  localparam logic [LPMS_W-1:0] LONG_PRESS_MS_RST    = 16'd1000;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [TIME_WIDTH-1:0]  tstamp_t;

  typedef struct packed {
    logic              averaging;
    logic [THR_W-1:0]  threshold;
    logic [LPMS_W-1:0] long_ms;
  } bdlp_cfg_t;

  typedef struct packed {
    logic    pressed;
    count_t  count;
    logic    long_flag;
    tstamp_t start_ms;
  } bdlp_state_t;

  typedef struct packed {
    logic pressed;
    logic click;
    logic long_press;
  } bdlp_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bdlp_step.sv =====
// Next-state and result logic for one button sample.
`default_nettype none

module bdlp_step (
  input  bdlp_pkg::bdlp_state_t  state,
  input  bdlp_pkg::bdlp_cfg_t    cfg,
  input  logic                   level,
  input  logic [bdlp_pkg::NOW_W-1:0] now_ms,
  output bdlp_pkg::bdlp_state_t  state_nxt,
  output bdlp_pkg::bdlp_result_t result
);
  import bdlp_pkg::*;

  localparam count_t COUNT_MAX = '1;

  tstamp_t          now_t;
  tstamp_t          start_nxt;
  tstamp_t          elapsed;
  count_t           count_inc;
  logic             agree;
  logic             toggle;
  logic             click;
  logic [CMP_W-1:0] inc_wide;
  logic [CMP_W-1:0] thr_wide;

  assign now_t     = TIME_WIDTH'(now_ms);
  // A sample agrees when the pin shows what the debounced state expects.
  assign agree     = (state.pressed != level);
  assign count_inc = (state.count != COUNT_MAX) ? count_t'(state.count + 1'b1) : state.count;
  assign inc_wide  = CMP_W'(count_inc);
  assign thr_wide  = CMP_W'(cfg.threshold);
  assign toggle    = !agree && (inc_wide >= thr_wide);
  assign start_nxt = (toggle && !state.pressed && cfg.averaging) ? now_t : state.start_ms;
  assign elapsed   = tstamp_t'(now_t - start_nxt);

  always_comb begin
    state_nxt = state;
    click     = 1'b0;
    if (agree) begin
      if (cfg.averaging) begin
        if (state.count != '0) begin
          state_nxt.count = count_t'(state.count - 1'b1);
        end
      end else begin
        state_nxt.count = '0;
      end
    end else if (toggle) begin
      state_nxt.pressed = !state.pressed;
      state_nxt.count   = '0;
      if (cfg.averaging) begin
        state_nxt.long_flag = 1'b0;
      end
      if (!state.pressed) begin
        click = 1'b1;
        if (cfg.averaging) begin
          state_nxt.start_ms = now_t;
        end
      end
    end else begin
      state_nxt.count = count_inc;
    end

    // The long-press test sees the state after any toggle of this sample.
    if (cfg.averaging && state_nxt.pressed && !state_nxt.long_flag) begin
      if (elapsed > TIME_WIDTH'(cfg.long_ms)) begin
        state_nxt.long_flag = 1'b1;
      end
    end

    result.pressed    = state_nxt.pressed;
    result.click      = click;
    result.long_press = state_nxt.long_flag;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/button_debouncer_long_press_unit.sv =====
// Top level of the button debouncer with click pulse and long-press flag.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_level, in_now_ms
//   out_     output     out_valid/out_ready  out_pressed, out_click, out_long_press
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each request is worked combinationally: its result is in the output register
// at the next edge, and a new request is taken every cycle unless the output stalls.
// in_ready falls only while a result waits and out_ready is low; the output
// register is the only stage, so throughput is one request per cycle while it is not stalled.
// Synchronous reset clears the debounce state and loads the register defaults.
// cfg_ready is always high; writes to an unused index are dropped.
`default_nettype none

module button_debouncer_long_press_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_level,
  input  logic [bdlp_pkg::NOW_W-1:0]       in_now_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_pressed,
  output logic                             out_click,
  output logic                             out_long_press,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bdlp_pkg::*;

  bdlp_cfg_t    cfg_r;
  bdlp_state_t  state_r;
  bdlp_state_t  state_nxt;
  bdlp_result_t res_r;
  bdlp_result_t res_nxt;
  logic         out_valid_r;
  logic         in_take;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  bdlp_step u_step (
    .state     (state_r),
    .cfg       (cfg_r),
    .level     (in_level),
    .now_ms    (in_now_ms),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.averaging <= FILTER_MODE_RST;
      cfg_r.threshold <= CONFIRM_THRESHOLD_RST;
      cfg_r.long_ms   <= LONG_PRESS_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FILTER_MODE:       cfg_r.averaging <= cfg_data[0];
        CFG_CONFIRM_THRESHOLD: cfg_r.threshold <= cfg_data[THR_W-1:0];
        CFG_LONG_PRESS_MS:     cfg_r.long_ms   <= cfg_data[LPMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        state_r <= state_nxt;
      end
      if (in_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pressed    = res_r.pressed;
  assign out_click      = res_r.click;
  assign out_long_press = res_r.long_press;

  a_click_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.click) |-> res_r.pressed)
    else $error("click shown without a pressed state");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (out_valid_r && (res_r.pressed == state_r.pressed)))
    else $error("accepted request did not reach the output register");

  a_scan_holds_long: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && !cfg_r.averaging) |=> $stable(state_r.long_flag))
    else $error("long-press flag moved in stable-scan mode");

  a_toggle_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (state_nxt.pressed != state_r.pressed)) |=> (state_r.count == '0))
    else $error("counter not cleared on a debounced toggle");

endmodule

`default_nettype wire

// ===== test/button_debouncer_long_press_unit_tb.sv =====
// Self-checking testbench for the button debouncer with click pulse and long-press flag.
`default_nettype none

module button_debouncer_long_press_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdlp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic             level;
    logic [NOW_W-1:0] now_ms;
  } sample_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_level = 1'b1;
  logic [NOW_W-1:0]      in_now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_pressed;
  logic                  out_click;
  logic                  out_long_press;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the block's registers and debounce state.
  bdlp_cfg_t    btn_cfg;
  bdlp_state_t  btn_state;

  sample_t      sample_queue[$];
  bdlp_result_t result_queue[$];
  sample_t      next_sample;
  bdlp_result_t oldest_result;

  int           samples_queued = 0;
  int           results_checked = 0;
  int           failures = 0;
  int           send_gap = 0;
  int           stall_len = 0;
  bit           no_gaps = 1'b0;
  logic [NOW_W-1:0] clock_ms = '0;

  button_debouncer_long_press_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_level       (in_level),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pressed    (out_pressed),
    .out_click      (out_click),
    .out_long_press (out_long_press),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pause_len();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bdlp_result_t debounce_step(input logic level, input tstamp_t now);
    bdlp_result_t res;
    tstamp_t      elapsed;
    res = '0;
    // A high pin agrees with released, a low pin with pressed.
    if (btn_state.pressed != level) begin
      if (!btn_cfg.averaging) begin
        btn_state.count = '0;
      end else if (btn_state.count != '0) begin
        btn_state.count = btn_state.count - 1'b1;
      end
    end else begin
      if (btn_state.count != '1) btn_state.count = btn_state.count + 1'b1;
      if (btn_state.count >= btn_cfg.threshold) begin
        btn_state.pressed = ~btn_state.pressed;
        btn_state.count = '0;
        if (btn_cfg.averaging) btn_state.long_flag = 1'b0;
        if (btn_state.pressed) begin
          res.click = 1'b1;
          if (btn_cfg.averaging) btn_state.start_ms = now;
        end
      end
    end
    if (btn_cfg.averaging && btn_state.pressed && !btn_state.long_flag) begin
      elapsed = now - btn_state.start_ms;
      if (elapsed > btn_cfg.long_ms) btn_state.long_flag = 1'b1;
    end
    res.pressed = btn_state.pressed;
    res.long_press = btn_state.long_flag;
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void compare_field(input string name, input logic exp, input logic act);
    if (act !== exp) begin
      note_failure($sformatf("result %0d: %s expected %0b got %0b",
                             results_checked, name, exp, act));
    end
  endfunction

  // Request driver: takes samples from the queue and predicts at acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        result_queue.push_back(debounce_step(in_level, tstamp_t'(in_now_ms)));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          next_sample = sample_queue.pop_front();
          in_valid <= 1'b1;
          in_level <= next_sample.level;
          in_now_ms <= next_sample.now_ms;
          send_gap = pause_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          note_failure($sformatf("unrequested result pressed=%0b click=%0b long_press=%0b",
                                 out_pressed, out_click, out_long_press));
        end else begin
          oldest_result = result_queue.pop_front();
          compare_field("pressed", oldest_result.pressed, out_pressed);
          compare_field("click", oldest_result.click, out_click);
          compare_field("long_press", oldest_result.long_press, out_long_press);
          results_checked++;
        end
      end
      if (stall_len > 0) begin
        stall_len--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_len = pause_len();
      end
    end
  end

  task automatic push_sample(input logic level, input logic [NOW_W-1:0] now);
    sample_queue.push_back('{level: level, now_ms: now});
    samples_queued++;
  endtask

  task automatic wait_drain();
    @(posedge clk);
    while (results_checked != samples_queued) @(posedge clk);
  endtask

  // Must be called right after a rising edge; leaves cfg_valid high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FILTER_MODE:       btn_cfg.averaging = data[0];
      CFG_CONFIRM_THRESHOLD: btn_cfg.threshold = data[THR_W-1:0];
      CFG_LONG_PRESS_MS:     btn_cfg.long_ms = data[LPMS_W-1:0];
      default: ;
    endcase
  endtask

  // Unused data bits carry random values to check that the block masks them.
  task automatic apply_settings(input logic mode, input logic [THR_W-1:0] thr,
                                input logic [LPMS_W-1:0] lp);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    write_reg(CFG_FILTER_MODE, {noise[CFG_DATA_W-1:1], mode});
    write_reg(CFG_CONFIRM_THRESHOLD, {noise[CFG_DATA_W-1:THR_W], thr});
    write_reg(CFG_LONG_PRESS_MS, lp);
    cfg_valid <= 1'b0;
  endtask

  // Mostly held levels long enough to toggle, with bounce and short noisy runs.
  task automatic run_phase(input logic mode, input int thr, input int lp, input int count,
                           input int step_max, input int bounce_pct, input bit calm);
    logic want;
    int   run;
    wait_drain();
    no_gaps = calm;
    apply_settings(mode, THR_W'(thr), LPMS_W'(lp));
    want = btn_state.pressed;
    run = $urandom_range(thr + 2, 3 * thr + 20);
    for (int k = 0; k < count; k++) begin
      if (run == 0) begin
        want = ~want;
        if ($urandom_range(0, 9) == 0) run = $urandom_range(1, 3);
        else run = $urandom_range(thr + 2, 3 * thr + 20);
      end
      run--;
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      push_sample(want ^ ($urandom_range(0, 99) < bounce_pct), clock_ms);
    end
  endtask

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    btn_cfg.averaging = FILTER_MODE_RST;
    btn_cfg.threshold = CONFIRM_THRESHOLD_RST;
    btn_cfg.long_ms = LONG_PRESS_MS_RST;
    btn_state = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values: two presses stay below the default threshold.
    push_sample(1'b0, 32'h0000_0000);
    push_sample(1'b0, 32'h0000_0000);

    // Zero threshold toggles at once; long press at zero time and across the wrap.
    wait_drain();
    apply_settings(1'b1, 8'd0, 16'd0);
    push_sample(1'b0, 32'h0000_0000);
    push_sample(1'b0, 32'h0000_0001);
    push_sample(1'b1, 32'hFFFF_FFFF);
    push_sample(1'b0, 32'hFFFF_FFFF);
    push_sample(1'b0, 32'h0000_0000);
    push_sample(1'b0, 32'hFFFF_FFFF);

    // Stable-scan: an agreeing sample clears the count, the long flag is held.
    wait_drain();
    apply_settings(1'b0, 8'd2, 16'hFFFF);
    push_sample(1'b1, 32'h0000_0010);
    push_sample(1'b0, 32'h0000_0011);
    push_sample(1'b1, 32'h0000_0012);
    push_sample(1'b1, 32'h0000_0013);
    push_sample(1'b0, 32'h0000_0014);
    push_sample(1'b0, 32'h7FFF_FFFF);

    // Long press must strictly exceed the limit; a write to the spare index is dropped.
    wait_drain();
    write_reg(CFG_UNUSED, 16'hFFFF);
    apply_settings(1'b1, 8'd1, 16'hFFFF);
    push_sample(1'b1, 32'h0000_0050);
    push_sample(1'b0, 32'h0000_0064);
    push_sample(1'b0, 32'h0001_0063);
    push_sample(1'b0, 32'h0001_0064);

    clock_ms = 32'hFFFF_F000;
    run_phase(1'b1, 15, 1000, 150, 60, 10, 1'b0);
    run_phase(1'b0, 255, 0, 300, 5, 0, 1'b0);
    run_phase(1'b1, 3, $urandom_range(0, 200), 200, 20, 15, 1'b0);
    run_phase(1'b0, 1, $urandom_range(0, 65535), 150, 20, 15, 1'b0);
    run_phase(1'b1, 0, 65535, 150, 40000, 10, 1'b0);
    run_phase(1'b1, $urandom_range(1, 8), $urandom_range(0, 300), 200, 20, 15, 1'b1);
    run_phase(1'b0, $urandom_range(1, 10), $urandom_range(0, 65535), 150, 20, 20, 1'b0);
    run_phase(1'b1, $urandom_range(2, 6), $urandom_range(0, 150), 100, 20, 15, 1'b0);

    wait_drain();
    repeat (5) @(posedge clk);
    if (result_queue.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", result_queue.size()));
    end
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
